// ===== rtl/core/jlcg_pkg.sv =====
// Shared types and constants for the 48-bit LCG random generator.
package jlcg_pkg;

    localparam int unsigned LCG_W = 48;

    localparam logic [34:0]      LCG_MULT = 35'h5DEECE66D;
    localparam logic [LCG_W-1:0] LCG_INC  = 48'hB;

    localparam logic [2:0] OP_SET_SEED = 3'd0;
    localparam logic [2:0] OP_INT      = 3'd1;
    localparam logic [2:0] OP_LONG     = 3'd2;
    localparam logic [2:0] OP_FLOAT    = 3'd3;
    localparam logic [2:0] OP_DOUBLE   = 3'd4;

    typedef struct packed {
        logic [2:0]          operation;
        logic signed [63:0]  seed_value;
        logic signed [31:0]  upper_bound;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0]  value;
        logic                bad_bound;
    } t_out_item;

endpackage

// ===== rtl/core/jlcg_step.sv =====
// LCG state advance: state * mult + inc mod 2^48, one 16-bit slice per cycle.
module jlcg_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_state,
    output logic        o_done,
    output logic [47:0] o_state
);
    import jlcg_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_cnt;
    logic [47:0] r_src;
    logic [47:0] r_acc;
    logic [15:0] w_chunk;
    logic [50:0] w_prod;
    logic [47:0] w_term;

    always_comb begin
        case (r_cnt)
            2'd0:    w_chunk = r_src[15:0];
            2'd1:    w_chunk = r_src[31:16];
            2'd2:    w_chunk = r_src[47:32];
            default: w_chunk = 16'd0;
        endcase
    end

    assign w_prod = {35'd0, w_chunk} * {16'd0, LCG_MULT};

    // slice weight 2^(16*cnt), truncated to 48 bits
    always_comb begin
        case (r_cnt)
            2'd0:    w_term = w_prod[47:0];
            2'd1:    w_term = {w_prod[31:0], 16'd0};
            2'd2:    w_term = {w_prod[15:0], 32'd0};
            default: w_term = 48'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src <= i_state;
            r_acc <= LCG_INC;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_done  = r_done;
    assign o_state = r_acc;

endmodule

// ===== rtl/core/jlcg_mod.sv =====
// Restoring bit-serial remainder of a 31-bit draw by a 31-bit bound.
module jlcg_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_dividend,
    input  logic [30:0] i_divisor,
    output logic        o_done,
    output logic [30:0] o_rem
);
    import jlcg_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [30:0] r_dvd;
    logic [30:0] r_dvs;
    logic [30:0] r_rem;
    logic [31:0] w_trial;
    logic [31:0] w_diff;
    logic [30:0] w_rem_nxt;

    assign w_trial   = {r_rem, r_dvd[30]};
    assign w_diff    = w_trial - {1'b0, r_dvs};
    assign w_rem_nxt = (w_trial >= {1'b0, r_dvs}) ? w_diff[30:0] : w_trial[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= 31'd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[29:0], 1'b0};
            r_rem <= w_rem_nxt;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/java_lcg_random_generator_unit.sv =====
// Top level: sequencer around the shared LCG step unit and the serial remainder unit.
// Sequence: set seed loads the state directly; float, long and double draw via the LCG step unit,
//   long and double again; power-of-two int bounds scale the draw, others loop step and remainder.
// Throughput: one item at a time; the input is ready only while the sequencer is idle.
// Reset (synchronous, active low): state loads 0x5DEECE66D as for seed zero, no result pending.
module java_lcg_random_generator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  jlcg_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output jlcg_pkg::t_out_item  o_out_item
);
    import jlcg_pkg::*;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,   // LCG step unit running
        S_DIV  = 4'b0100,   // remainder unit running (bounded int)
        S_DONE = 4'b1000    // result ready, waiting for the output register
    } t_fsm;

    t_fsm        r_fsm, n_fsm;
    logic [47:0] r_lcg;          // generator state
    logic [2:0]  r_op;
    logic [30:0] r_bound;        // bound, low 31 bits; positive whenever the step path uses it
    logic        r_second;       // second draw of long / double
    logic [31:0] r_hold;         // first draw of long / double
    logic [30:0] r_draw;         // 31-bit draw under test in the rejection loop
    t_out_item   r_res;
    t_out_item   r_out;
    logic        r_out_valid;

    logic        w_accept;
    logic        w_bad;
    logic        w_step_start;
    logic        w_step_done;
    logic [47:0] w_step_src;
    logic [47:0] w_new;
    logic        w_div_start;
    logic        w_div_done;
    logic [30:0] w_rem;
    logic        w_pow2;
    logic [61:0] w_pprod;
    logic [31:0] w_test;
    logic        w_reject;
    logic [63:0] w_long;
    logic        w_out_free;

    // a back-to-back second draw starts from the state that just came out
    assign w_step_src = w_step_done ? w_new : r_lcg;

    jlcg_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_step_start),
        .i_state (w_step_src),
        .o_done  (w_step_done),
        .o_state (w_new)
    );

    jlcg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_new[47:17]),
        .i_divisor  (r_bound),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign o_in_ready = (r_fsm == S_IDLE) && i_rst_n;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_bad      = i_in_item.upper_bound[31] | (i_in_item.upper_bound == 32'sd0);
    assign w_out_free = !r_out_valid || i_out_ready;

    // bound & -bound == bound  <=>  single bit set
    assign w_pow2  = ((r_bound & (~r_bound + 31'd1)) == r_bound);
    // power-of-two path: (bound * r) >> 31
    assign w_pprod = {31'd0, r_bound} * {31'd0, w_new[47:17]};

    // rejection test: r - v + (bound - 1) must not go negative as a 32-bit int
    assign w_test   = {1'b0, r_draw} - {1'b0, w_rem} + {1'b0, r_bound} - 32'd1;
    assign w_reject = w_test[31];

    // long: hi * 2^32 + sign-extended lo
    assign w_long = {r_hold, 32'd0} + {{32{w_new[47]}}, w_new[47:16]};

    // sequencer
    always_comb begin
        n_fsm        = r_fsm;
        w_step_start = 1'b0;
        w_div_start  = 1'b0;
        case (r_fsm)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.operation)
                        OP_INT: begin
                            if (w_bad) begin
                                n_fsm = S_DONE;
                            end else begin
                                w_step_start = 1'b1;
                                n_fsm        = S_MUL;
                            end
                        end
                        OP_LONG, OP_FLOAT, OP_DOUBLE: begin
                            w_step_start = 1'b1;
                            n_fsm        = S_MUL;
                        end
                        default: n_fsm = S_DONE;   // set seed and unknown codes
                    endcase
                end
            end
            S_MUL: begin
                if (w_step_done) begin
                    case (r_op)
                        OP_INT: begin
                            if (w_pow2) begin
                                n_fsm = S_DONE;
                            end else begin
                                w_div_start = 1'b1;
                                n_fsm       = S_DIV;
                            end
                        end
                        OP_LONG, OP_DOUBLE: begin
                            if (!r_second) begin
                                w_step_start = 1'b1;
                            end else begin
                                n_fsm = S_DONE;
                            end
                        end
                        default: n_fsm = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_reject) begin
                        w_step_start = 1'b1;   // draw again
                        n_fsm        = S_MUL;
                    end else begin
                        n_fsm = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_fsm = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_lcg       <= {13'd0, LCG_MULT};
            r_out_valid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (w_accept && (i_in_item.operation == OP_SET_SEED)) begin
                r_lcg <= i_in_item.seed_value[47:0] ^ {13'd0, LCG_MULT};
            end else if (w_step_done) begin
                r_lcg <= w_new;
            end
            if ((r_fsm == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op            <= i_in_item.operation;
            r_bound         <= i_in_item.upper_bound[30:0];
            r_second        <= 1'b0;
            r_res.value     <= 64'sd0;
            r_res.bad_bound <= (i_in_item.operation == OP_INT) && w_bad;
        end
        if ((r_fsm == S_MUL) && w_step_done) begin
            r_draw <= w_new[47:17];
            case (r_op)
                OP_INT: begin
                    r_res.value <= {33'd0, w_pprod[61:31]};
                end
                OP_LONG: begin
                    r_second <= 1'b1;
                    r_hold   <= w_new[47:16];
                    if (r_second) begin
                        r_res.value <= w_long;
                    end
                end
                OP_FLOAT: begin
                    r_res.value <= {40'd0, w_new[47:24]};
                end
                OP_DOUBLE: begin
                    r_second <= 1'b1;
                    r_hold   <= {6'd0, w_new[47:22]};
                    if (r_second) begin
                        r_res.value <= {11'd0, r_hold[25:0], w_new[47:21]};
                    end
                end
                default: r_res.value <= 64'sd0;
            endcase
        end
        if ((r_fsm == S_DIV) && w_div_done) begin
            r_res.value <= {33'd0, w_rem};
        end
        if ((r_fsm == S_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // step unit only finishes while the sequencer waits on it
    a_step_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_done |-> (r_fsm == S_MUL))
        else $error("LCG step finished outside S_MUL");

    // remainder unit only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_fsm == S_DIV))
        else $error("remainder finished outside S_DIV");

    // a rejected bound never carries a value
    a_bad_bound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.bad_bound) |-> (o_out_item.value == 64'sd0))
        else $error("bad bound item with nonzero value");

    // set seed loads the masked, scrambled seed
    a_set_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_item.operation == OP_SET_SEED))
        |=> (r_lcg == ($past(i_in_item.seed_value[47:0]) ^ {13'd0, LCG_MULT})))
        else $error("set seed loaded wrong state");

endmodule
